@@ src/pdcp_rx_count_reorder_window_defines.svh @@
`ifndef PDCP_RX_COUNT_REORDER_WINDOW_DEFINES_SVH
`define PDCP_RX_COUNT_REORDER_WINDOW_DEFINES_SVH

// Same-cycle implication, checked on clk_i, quiet while rst_ni is low
`define PRCRW_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i, quiet while rst_ni is low
`define PRCRW_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ src/prcrw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package prcrw_pkg;

  // Default reorder ring depth
  localparam int unsigned WINDOW_SLOTS_DEF = 32;

  // Configuration register indexes
  localparam logic [1:0] REG_LONG_SN_MODE      = 2'd0;
  localparam logic [1:0] REG_SIGNALLING_BEARER = 2'd1;
  localparam logic [1:0] REG_INTEGRITY_ON      = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_DELIVERED = 3'd0;
  localparam logic [2:0] ST_TOO_SHORT = 3'd1;
  localparam logic [2:0] ST_ALREADY   = 3'd2;
  localparam logic [2:0] ST_DUPLICATE = 3'd3;
  localparam logic [2:0] ST_HELD      = 3'd4;

  // Header and trailer sizes in bytes
  localparam logic [13:0] HDR_LEN_SHORT = 14'd2;
  localparam logic [13:0] HDR_LEN_LONG  = 14'd3;
  localparam logic [13:0] MACI_LEN      = 14'd4;

  typedef struct packed {
    logic [7:0]  header_byte0;
    logic [7:0]  header_byte1;
    logic [7:0]  header_byte2;
    logic [13:0] pdu_length;
    logic [15:0] payload_tag;
  } in_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] pdu_count;
    logic [15:0] out_tag;
    logic [13:0] sdu_length;
    logic        last;
  } out_res_t;

endpackage

`default_nettype wire

@@ src/pdcp_rx_count_reorder_window.sv @@
// Channel  Handshake                Payload                Direction
// cfg      cfg_we_i                 cfg_idx_i, cfg_data_i  in
// in       in_valid_i / in_stall_o  in_data_i (in_req_t)   in
// out      out_valid_o / out_stall_i out_data_o (out_res_t) out
//
// One request at a time: a new request is taken only once the current one has finished.
// Each delivered slot goes through a slot RAM read, then the result register. A forced walk
// steps over the empty slots one by one, then closes the walk and rechecks the head.
// Reset (rst_ni low, async) empties the window: no clearing pass is needed.
// A stalled output holds the sequencer in its emit or finish step; in_stall_o stays high
// until the last result of the current request has reached the output register.
`timescale 1ns / 1ps
`default_nettype none
`include "pdcp_rx_count_reorder_window_defines.svh"

module pdcp_rx_count_reorder_window #(
  parameter int unsigned WINDOW_SLOTS = prcrw_pkg::WINDOW_SLOTS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_idx_i,
  input  wire logic                cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire prcrw_pkg::in_req_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output prcrw_pkg::out_res_t      out_data_o
);

  localparam int unsigned IW = $clog2(WINDOW_SLOTS);
  localparam int unsigned LW = $clog2(WINDOW_SLOTS + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(WINDOW_SLOTS - 1);
  localparam logic [IW:0]   WIN_I    = (IW + 1)'(WINDOW_SLOTS);
  localparam logic [31:0]   WIN32    = 32'(WINDOW_SLOTS);
  localparam logic [LW-1:0] WIN_L    = LW'(WINDOW_SLOTS);

  // Sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_PARSE  = 4'd1;
  localparam logic [3:0] S_CALC   = 4'd2;
  localparam logic [3:0] S_CHECK  = 4'd3;
  localparam logic [3:0] S_FORCE  = 4'd4;
  localparam logic [3:0] S_DRAIN  = 4'd5;
  localparam logic [3:0] S_STORE  = 4'd6;
  localparam logic [3:0] S_EMIT   = 4'd7;
  localparam logic [3:0] S_FINISH = 4'd8;

  typedef struct packed {
    logic [15:0] tag;
    logic [13:0] len;
  } slot_t;

  // Control state
  logic [3:0]              state_q, state_d, ret_q, ret_d;
  logic                    long_q, long_d, sig_q, sig_d, integ_q, integ_d;
  logic [31:0]             ndc_q, ndc_d;
  logic [IW-1:0]           head_q, head_d;
  logic [WINDOW_SLOTS-1:0] full_q, full_d;
  logic [LW-1:0]           held_q, held_d;
  logic                    stored_q, stored_d;
  logic                    pend_v_q, pend_v_d, out_v_q, out_v_d;

  // Per-request working registers
  prcrw_pkg::in_req_t      req_q, req_d;
  logic [17:0]             sn_q, sn_d;
  logic [13:0]             sdu_q, sdu_d;
  logic                    up_q, up_d, down_q, down_d, stale_q, stale_d;
  logic [31:0]             count_q, count_d, num_q, num_d, cur_q, cur_d;
  logic [LW-1:0]           lim_q, lim_d;
  prcrw_pkg::out_res_t     res_q, res_d, pend_q, pend_d, out_q, out_d;
  logic                    use_rd_q, use_rd_d;

  // Slot RAM
  slot_t                   mem_q [WINDOW_SLOTS];
  slot_t                   rd_q;
  logic                    mem_we, mem_re;
  logic [IW-1:0]           mem_waddr;
  slot_t                   mem_wdata;

  // Header parse
  logic [13:0] hdr_len, trl_len, min_len, sdu_w;
  logic        short_w, up_w, down_w;
  logic [17:0] sn_w, half_w, dsn_w;
  logic [31:0] dhfn_w, hfn_w, count_w, off_w, num_w;
  logic [IW:0] idx_sum;
  logic [IW-1:0] idx_w, head_inc;
  logic        can_push, push, fin, move_out;
  prcrw_pkg::out_res_t new_res;

  assign hdr_len = long_q ? prcrw_pkg::HDR_LEN_LONG : prcrw_pkg::HDR_LEN_SHORT;
  assign trl_len = (sig_q || integ_q) ? prcrw_pkg::MACI_LEN : 14'd0;
  assign min_len = hdr_len + trl_len + 14'd1;
  assign short_w = req_q.pdu_length < min_len;
  assign sdu_w   = req_q.pdu_length - hdr_len - trl_len;

  assign sn_w   = long_q ? {req_q.header_byte0[1:0], req_q.header_byte1, req_q.header_byte2}
                         : {6'd0, req_q.header_byte0[3:0], req_q.header_byte1};
  assign half_w = long_q ? 18'h20000 : 18'h00800;
  assign dsn_w  = long_q ? ndc_q[17:0] : {6'd0, ndc_q[11:0]};
  assign dhfn_w = long_q ? {18'd0, ndc_q[31:18]} : {12'd0, ndc_q[31:12]};
  assign up_w   = (dsn_w >= half_w) && (sn_w < (dsn_w - half_w));
  assign down_w = {1'b0, sn_w} >= ({1'b0, dsn_w} + {1'b0, half_w});

  // COUNT rebuild from the registered window decision
  assign hfn_w   = up_q ? (dhfn_w + 32'd1) : (down_q ? (dhfn_w - 32'd1) : dhfn_w);
  assign count_w = long_q ? {hfn_w[13:0], sn_q} : {hfn_w[19:0], sn_q[11:0]};

  assign off_w    = count_q - ndc_q;
  assign num_w    = off_w - (WIN32 - 32'd1);
  assign idx_sum  = {1'b0, head_q} + {1'b0, off_w[IW-1:0]};
  assign idx_w    = (idx_sum >= WIN_I) ? IW'(idx_sum - WIN_I) : idx_sum[IW-1:0];
  assign head_inc = (head_q == LAST_IDX) ? '0 : head_q + IW'(1);

  assign can_push = !pend_v_q || !out_v_q || !out_stall_i;

  // Result source: slot RAM data for deliveries, else the prepared result
  always_comb begin
    new_res = res_q;
    if (use_rd_q) begin
      new_res.out_tag    = rd_q.tag;
      new_res.sdu_length = rd_q.len;
    end
    new_res.last = 1'b0;
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    long_d    = long_q;
    sig_d     = sig_q;
    integ_d   = integ_q;
    ndc_d     = ndc_q;
    head_d    = head_q;
    full_d    = full_q;
    held_d    = held_q;
    stored_d  = stored_q;
    req_d     = req_q;
    sn_d      = sn_q;
    sdu_d     = sdu_q;
    up_d      = up_q;
    down_d    = down_q;
    stale_d   = stale_q;
    count_d   = count_q;
    num_d     = num_q;
    cur_d     = cur_q;
    lim_d     = lim_q;
    res_d     = res_q;
    use_rd_d  = use_rd_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = idx_w;
    mem_wdata = '{tag: req_q.payload_tag, len: sdu_q};
    push      = 1'b0;
    fin       = 1'b0;

    // Configuration writes
    if (cfg_we_i) begin
      case (cfg_idx_i)
        prcrw_pkg::REG_LONG_SN_MODE:      long_d  = cfg_data_i;
        prcrw_pkg::REG_SIGNALLING_BEARER: sig_d   = cfg_data_i;
        prcrw_pkg::REG_INTEGRITY_ON:      integ_d = cfg_data_i;
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d   = in_data_i;
          state_d = S_PARSE;
        end
      end
      S_PARSE: begin
        sn_d     = sn_w;
        sdu_d    = sdu_w;
        up_d     = up_w;
        down_d   = down_w && !up_w;
        stale_d  = down_w && !up_w && (dhfn_w == 32'd0);
        stored_d = 1'b0;
        if (short_w) begin
          res_d    = '{status: prcrw_pkg::ST_TOO_SHORT, default: '0};
          use_rd_d = 1'b0;
          ret_d    = S_FINISH;
          state_d  = S_EMIT;
        end else begin
          state_d = S_CALC;
        end
      end
      S_CALC: begin
        count_d = count_w;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (stale_q || (count_q < ndc_q)) begin
          res_d    = '{status: prcrw_pkg::ST_ALREADY, pdu_count: count_q, default: '0};
          use_rd_d = 1'b0;
          ret_d    = S_FINISH;
          state_d  = S_EMIT;
        end else if (off_w >= WIN32) begin
          num_d   = num_w;
          lim_d   = (num_w >= WIN32) ? WIN_L : num_w[LW-1:0];
          cur_d   = ndc_q;
          state_d = S_FORCE;
        end else begin
          state_d = S_STORE;
        end
      end
      // Forced walk over the oldest slots
      S_FORCE: begin
        if (lim_q == '0) begin
          ndc_d   = ndc_q + num_q;
          state_d = S_DRAIN;
        end else begin
          lim_d  = lim_q - LW'(1);
          cur_d  = cur_q + 32'd1;
          head_d = head_inc;
          if (full_q[head_q]) begin
            mem_re         = 1'b1;
            full_d[head_q] = 1'b0;
            held_d         = held_q - LW'(1);
            res_d    = '{status: prcrw_pkg::ST_DELIVERED, pdu_count: cur_q, default: '0};
            use_rd_d = 1'b1;
            ret_d    = S_FORCE;
            state_d  = S_EMIT;
          end
        end
      end
      // In-order release of consecutive full slots
      S_DRAIN: begin
        if (full_q[head_q]) begin
          mem_re         = 1'b1;
          full_d[head_q] = 1'b0;
          held_d         = held_q - LW'(1);
          ndc_d          = ndc_q + 32'd1;
          head_d         = head_inc;
          res_d    = '{status: prcrw_pkg::ST_DELIVERED, pdu_count: ndc_q, default: '0};
          use_rd_d = 1'b1;
          ret_d    = S_DRAIN;
          state_d  = S_EMIT;
        end else begin
          state_d = stored_q ? S_FINISH : S_STORE;
        end
      end
      S_STORE: begin
        if (full_q[idx_w]) begin
          res_d    = '{status: prcrw_pkg::ST_DUPLICATE, pdu_count: count_q, default: '0};
          use_rd_d = 1'b0;
          ret_d    = S_FINISH;
          state_d  = S_EMIT;
        end else begin
          mem_we        = 1'b1;
          full_d[idx_w] = 1'b1;
          held_d        = held_q + LW'(1);
          stored_d      = 1'b1;
          if (count_q == ndc_q) begin
            state_d = S_DRAIN;
          end else if (!pend_v_q) begin
            res_d    = '{status: prcrw_pkg::ST_HELD, pdu_count: count_q,
                         out_tag: req_q.payload_tag, sdu_length: sdu_q, last: 1'b0};
            use_rd_d = 1'b0;
            ret_d    = S_FINISH;
            state_d  = S_EMIT;
          end else begin
            state_d = S_FINISH;
          end
        end
      end
      S_EMIT: begin
        if (can_push) begin
          push    = 1'b1;
          state_d = ret_q;
        end
      end
      S_FINISH: begin
        if (!out_v_q || !out_stall_i) begin
          fin     = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // One-deep pending stage: a result goes out once its successor (or the end) is known
  assign move_out = (push && pend_v_q) || fin;

  always_comb begin
    pend_v_d = pend_v_q;
    pend_d   = pend_q;
    out_v_d  = out_v_q;
    out_d    = out_q;
    if (move_out) begin
      out_d      = pend_q;
      out_d.last = fin;
      out_v_d    = 1'b1;
    end else if (out_v_q && !out_stall_i) begin
      out_v_d = 1'b0;
    end
    if (push) begin
      pend_d   = new_res;
      pend_v_d = 1'b1;
    end else if (fin) begin
      pend_v_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ret_q    <= S_IDLE;
      long_q   <= 1'b1;
      sig_q    <= 1'b0;
      integ_q  <= 1'b0;
      ndc_q    <= '0;
      head_q   <= '0;
      full_q   <= '0;
      held_q   <= '0;
      stored_q <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      ret_q    <= ret_d;
      long_q   <= long_d;
      sig_q    <= sig_d;
      integ_q  <= integ_d;
      ndc_q    <= ndc_d;
      head_q   <= head_d;
      full_q   <= full_d;
      held_q   <= held_d;
      stored_q <= stored_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    sn_q     <= sn_d;
    sdu_q    <= sdu_d;
    up_q     <= up_d;
    down_q   <= down_d;
    stale_q  <= stale_d;
    count_q  <= count_d;
    num_q    <= num_d;
    cur_q    <= cur_d;
    lim_q    <= lim_d;
    res_q    <= res_d;
    use_rd_q <= use_rd_d;
    pend_q   <= pend_d;
    out_q    <= out_d;
  end

  // Slot RAM: one write port, one registered read port at the window head
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem_q[head_q];
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // Checks
  `PRCRW_ASSERT_IMP(a_held_matches_full, 1'b1, held_q == LW'($countones(full_q)),
    "held count out of step with slot occupancy")
  `PRCRW_ASSERT_IMP(a_finish_has_result, state_q == S_FINISH, pend_v_q,
    "request finishing without any result")
  `PRCRW_ASSERT_IMP(a_idle_no_pending, state_q == S_IDLE, !pend_v_q,
    "result left pending after request end")
  `PRCRW_ASSERT_NXT(a_drain_advances, (state_q == S_DRAIN) && full_q[head_q],
    ndc_q == $past(ndc_q) + 32'd1, "in-order delivery did not advance COUNT")

endmodule

`default_nettype wire

@@ bench/pdcp_rx_count_reorder_window_tb.sv @@
`timescale 1ns / 1ps

module pdcp_rx_count_reorder_window_tb;

  localparam int unsigned RING = prcrw_pkg::WINDOW_SLOTS_DEF;
  localparam int unsigned STALL_MAX = 17;
  localparam int unsigned QUIET_LIMIT = 3000;

  logic     clk_i;
  logic     rst_n;
  logic     cfg_we;
  logic [1:0] cfg_idx;
  logic     cfg_data;
  logic     in_valid;
  logic     in_stall;
  prcrw_pkg::in_req_t  in_pdu;
  logic     out_valid;
  logic     out_stall;
  prcrw_pkg::out_res_t out_res;

  pdcp_rx_count_reorder_window dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_pdu),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_res)
  );

  // Local copy of the configuration (reset values of the block)
  bit sn18_mode = 1'b1;
  bit srb_mode  = 1'b0;
  bit maci_on   = 1'b0;

  // Reorder window as the bench expects it
  logic [31:0] due_count;
  logic [31:0] ring_head;
  bit          ring_full [RING];
  logic [15:0] ring_tag  [RING];
  logic [13:0] ring_len  [RING];

  prcrw_pkg::out_res_t step_results[$];
  prcrw_pkg::out_res_t due_results[$];
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  bit steady = 1'b0;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Window predictor
  // ---------------------------------------------------------------------------

  function automatic void add_result(logic [2:0] st, logic [31:0] cnt, logic [15:0] tag,
                                     logic [13:0] len);
    prcrw_pkg::out_res_t r;
    r.status     = st;
    r.pdu_count  = cnt;
    r.out_tag    = tag;
    r.sdu_length = len;
    r.last       = 1'b0;
    if (step_results.size() < RING) step_results.push_back(r);
  endfunction

  function automatic void release_slot(logic [31:0] idx, logic [31:0] cnt);
    add_result(prcrw_pkg::ST_DELIVERED, cnt, ring_tag[idx], ring_len[idx]);
    ring_full[idx] = 1'b0;
  endfunction

  // Hand out the run of stored entries starting at the next COUNT due
  function automatic void drain_ready();
    for (int k = 0; k < RING; k++) begin
      if (!ring_full[ring_head]) break;
      release_slot(ring_head, due_count);
      due_count = due_count + 32'd1;
      ring_head = (ring_head + 32'd1) % RING;
    end
  endfunction

  // Works out every result one accepted PDU causes and queues them
  function automatic void reorder_pdu(prcrw_pkg::in_req_t r);
    logic [31:0] sn, hdr, trl, sdu, smask, half, dsn, dhfn, hfn, cnt, off, num, lim, idx;
    int unsigned bits;
    bit stale;
    prcrw_pkg::out_res_t res;
    step_results.delete();
    if (sn18_mode) begin
      sn   = {14'd0, r.header_byte0[1:0], r.header_byte1, r.header_byte2};
      hdr  = 32'(prcrw_pkg::HDR_LEN_LONG);
      bits = 18;
    end else begin
      sn   = {20'd0, r.header_byte0[3:0], r.header_byte1};
      hdr  = 32'(prcrw_pkg::HDR_LEN_SHORT);
      bits = 12;
    end
    trl = (maci_on || srb_mode) ? 32'(prcrw_pkg::MACI_LEN) : 32'd0;

    if (32'(r.pdu_length) < hdr + trl + 32'd1) begin
      add_result(prcrw_pkg::ST_TOO_SHORT, '0, '0, '0);
    end else begin
      sdu   = 32'(r.pdu_length) - hdr - trl;
      smask = (32'd1 << bits) - 32'd1;
      half  = 32'd1 << (bits - 1);
      dsn   = due_count & smask;
      dhfn  = due_count >> bits;
      hfn   = dhfn;
      stale = 1'b0;
      // COUNT rebuild over a half-SN-space window around the next COUNT due
      if (dsn >= half && sn < dsn - half) begin
        hfn = dhfn + 32'd1;
      end else if (sn >= dsn + half) begin
        stale = (dhfn == 0);
        hfn   = dhfn - 32'd1;
      end
      cnt = (hfn << bits) | sn;

      if (stale || cnt < due_count) begin
        add_result(prcrw_pkg::ST_ALREADY, cnt, '0, '0);
      end else begin
        off = cnt - due_count;
        // Too far ahead: push the oldest slots out first
        if (off >= RING) begin
          num = off - RING + 32'd1;
          lim = (num < RING) ? num : RING;
          for (int unsigned i = 0; i < lim; i++) begin
            idx = (ring_head + i) % RING;
            if (ring_full[idx]) release_slot(idx, due_count + i);
          end
          due_count = due_count + num;
          ring_head = (ring_head + num % RING) % RING;
          drain_ready();
          off = cnt - due_count;
        end
        idx = (ring_head + off) % RING;
        if (ring_full[idx]) begin
          add_result(prcrw_pkg::ST_DUPLICATE, cnt, '0, '0);
        end else begin
          ring_full[idx] = 1'b1;
          ring_tag[idx]  = r.payload_tag;
          ring_len[idx]  = sdu[13:0];
          if (cnt == due_count) drain_ready();
          else if (step_results.size() == 0)
            add_result(prcrw_pkg::ST_HELD, cnt, r.payload_tag, sdu[13:0]);
        end
      end
    end

    foreach (step_results[i]) begin
      res = step_results[i];
      res.last = (i == step_results.size() - 1);
      due_results.push_back(res);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Request helpers
  // ---------------------------------------------------------------------------

  function automatic int unsigned min_len();
    return 32'(sn18_mode ? prcrw_pkg::HDR_LEN_LONG : prcrw_pkg::HDR_LEN_SHORT)
           + ((srb_mode || maci_on) ? 32'(prcrw_pkg::MACI_LEN) : 32'd0) + 32'd1;
  endfunction

  // Header carrying the SN bits of a COUNT; spare header bits are random
  function automatic prcrw_pkg::in_req_t pdu_for(logic [31:0] cnt, logic [13:0] len,
                                                 logic [15:0] tag);
    prcrw_pkg::in_req_t r;
    r.header_byte0 = 8'($urandom);
    r.header_byte1 = 8'($urandom);
    r.header_byte2 = 8'($urandom);
    if (sn18_mode) begin
      r.header_byte0[1:0] = cnt[17:16];
      r.header_byte1      = cnt[15:8];
      r.header_byte2      = cnt[7:0];
    end else begin
      r.header_byte0[3:0] = cnt[11:8];
      r.header_byte1      = cnt[7:0];
    end
    r.pdu_length  = len;
    r.payload_tag = tag;
    return r;
  endfunction

  // Entered and left at a falling edge; valid is kept high only for a back-to-back request
  task automatic push_pdu(prcrw_pkg::in_req_t req);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, STALL_MAX);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_pdu   <= req;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    reorder_pdu(req);
    @(negedge clk_i);
  endtask

  // Stop sending and wait for every outstanding result, then let the block go idle
  task automatic settle();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(negedge clk_i);
    repeat (24) @(negedge clk_i);
  endtask

  task automatic configure(bit lng, bit srb, bit mac);
    settle();
    cfg_we   <= 1'b1;
    cfg_idx  <= prcrw_pkg::REG_LONG_SN_MODE;
    cfg_data <= lng;
    @(negedge clk_i);
    cfg_idx  <= prcrw_pkg::REG_SIGNALLING_BEARER;
    cfg_data <= srb;
    @(negedge clk_i);
    cfg_idx  <= prcrw_pkg::REG_INTEGRITY_ON;
    cfg_data <= mac;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
    sn18_mode = lng;
    srb_mode  = srb;
    maci_on   = mac;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset settings: in-order delivery, holding, release, repeats, short and stale PDUs
  task automatic test_in_order();
    prcrw_pkg::in_req_t req;
    push_pdu(pdu_for(32'd0, 14'h3fff, 16'hffff));
    push_pdu(pdu_for(32'd2, 14'd4, 16'h0000));
    push_pdu(pdu_for(32'd1, 14'd100, 16'h1234));
    push_pdu(pdu_for(32'd1, 14'd100, 16'h4321));
    push_pdu(pdu_for(32'd5, 14'd9000, 16'h5555));
    push_pdu(pdu_for(32'd5, 14'd9001, 16'haaaa));
    push_pdu(pdu_for(32'd3, 14'd50, 16'h0f0f));
    push_pdu(pdu_for(32'd4, 14'd51, 16'hf0f0));
    push_pdu(pdu_for(32'd6, 14'd3, 16'h7777));
    // SN far above the window while the HFN is still zero
    req = '{header_byte0: 8'hff, header_byte1: 8'hff, header_byte2: 8'hff,
            pdu_length: 14'h3fff, payload_tag: 16'hffff};
    push_pdu(req);
    req = '{header_byte0: 8'h00, header_byte1: 8'h00, header_byte2: 8'h00,
            pdu_length: 14'd0, payload_tag: 16'h0000};
    push_pdu(req);
  endtask

  // PDUs beyond the ring force the oldest slots out, full and empty ones
  task automatic test_window_overflow();
    logic [31:0] base;
    base = due_count;
    push_pdu(pdu_for(base + 32'd1, 14'd20, 16'h0101));
    push_pdu(pdu_for(base + 32'd3, 14'd21, 16'h0303));
    push_pdu(pdu_for(base + 32'd31, 14'd22, 16'h3131));
    push_pdu(pdu_for(base + 32'd45, 14'd23, 16'h4545));
    push_pdu(pdu_for(due_count + 32'd5000, 14'd24, 16'h5000));
  endtask

  // 12-bit SNs: jumps carry the HFN up, then a PDU half a space back.
  // A wrap of the full 32-bit COUNT would need over two million jumps.
  task automatic test_hfn_wrap();
    configure(1'b0, 1'b0, 1'b0);
    repeat (3) push_pdu(pdu_for(due_count + 32'd2047, 14'($urandom_range(3, 16383)),
                                16'($urandom)));
    push_pdu(pdu_for(due_count - 32'd2048, 14'd40, 16'hbeef));
  endtask

  // Trailer sizes move the too-short boundary
  task automatic test_trailer_sizes();
    configure(1'b0, 1'b1, 1'b0);
    push_pdu(pdu_for(due_count, 14'd6, 16'h0006));
    push_pdu(pdu_for(due_count, 14'd7, 16'h0007));
    configure(1'b0, 1'b0, 1'b1);
    push_pdu(pdu_for(due_count, 14'd6, 16'h0016));
    push_pdu(pdu_for(due_count + 32'd3, 14'h3fff, 16'h3fff));
    configure(1'b1, 1'b1, 1'b1);
    push_pdu(pdu_for(due_count, 14'd7, 16'h0107));
    push_pdu(pdu_for(due_count, 14'd8, 16'h0108));
  endtask

  // Mostly well-formed traffic near the next COUNT due, plus jumps, old and short PDUs
  task automatic random_pdus(int unsigned n);
    int unsigned pick, span;
    logic [31:0] cnt;
    logic [13:0] len;
    prcrw_pkg::in_req_t req;
    repeat (n) begin
      span = sn18_mode ? 131072 : 2048;
      pick = $urandom_range(0, 99);
      len  = 14'($urandom_range(min_len(), 16383));
      if ($urandom_range(0, 3) == 0) len = 14'(min_len() + $urandom_range(0, 2));
      if (pick < 25) cnt = due_count;
      else if (pick < 62) cnt = due_count + $urandom_range(1, 12);
      else if (pick < 72)
        cnt = due_count + (($urandom_range(0, 4) == 0) ? $urandom_range(32, span - 1)
                                                          : $urandom_range(28, 56));
      else if (pick < 82) cnt = due_count - $urandom_range(1, span);
      else cnt = $urandom;
      req = pdu_for(cnt, len, 16'($urandom));
      if (pick >= 82 && pick < 90) req.pdu_length = 14'($urandom_range(0, min_len() - 1));
      else if (pick >= 90) req.pdu_length = 14'($urandom_range(0, 16383));
      // now and then hold off until the block has emptied
      if ($urandom_range(0, 39) == 0) settle();
      push_pdu(req);
    end
  endtask

  task automatic test_random_traffic();
    configure(1'b1, 1'b0, 1'b0);
    random_pdus(50);
    configure(1'b0, 1'b1, 1'b0);
    steady = 1'b1;
    random_pdus(40);
    steady = 1'b0;
    configure(1'b1, 1'b1, 1'b1);
    random_pdus(50);
    configure(1'b0, 1'b0, 1'b1);
    random_pdus(50);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = prcrw_pkg::REG_LONG_SN_MODE;
    cfg_data  = 1'b0;
    in_valid  = 1'b0;
    in_pdu    = '0;
    due_count = '0;
    ring_head = '0;
    foreach (ring_full[i]) ring_full[i] = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);

    test_in_order();
    test_window_overflow();
    test_hfn_wrap();
    test_trailer_sizes();
    test_random_traffic();
    settle();

    if (mismatches == 0) $display("** pdcp_rx_count_reorder_window: PASSED **");
    else $display("** pdcp_rx_count_reorder_window: FAILED **");
    $finish;
  end

  // Result stall: a random hold before each result, none in steady stretches
  initial begin : result_stall
    int unsigned hold;
    out_stall <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk_i);
      hold = steady ? 0 : $urandom_range(0, STALL_MAX);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk_i);
        out_stall <= 1'b0;
      end
      @(posedge clk_i);
      while (!(out_valid && !out_stall)) @(posedge clk_i);
    end
  end

  // ---------------------------------------------------------------------------
  // Result check
  // ---------------------------------------------------------------------------

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    prcrw_pkg::out_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        $error("result with nothing expected: status %0d count 0x%0h", out_res.status,
               out_res.pdu_count);
        mismatches++;
      end else begin
        want = due_results.pop_front();
        check_field("status", 32'(want.status), 32'(out_res.status));
        check_field("pdu_count", want.pdu_count, out_res.pdu_count);
        check_field("out_tag", 32'(want.out_tag), 32'(out_res.out_tag));
        check_field("sdu_length", 32'(want.sdu_length), 32'(out_res.sdu_length));
        check_field("last", 32'(want.last), 32'(out_res.last));
      end
    end
  end

  // Watchdog: too long without any request or result moving
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("** pdcp_rx_count_reorder_window: FAILED **");
        $finish;
      end
    end
  end

endmodule

@@ sim.f @@
+incdir+src
src/prcrw_pkg.sv
src/pdcp_rx_count_reorder_window.sv
bench/pdcp_rx_count_reorder_window_tb.sv
